/* rtl/frl_pkg.sv */
// shared types, constants and register codes of the fault restart limiter
package frl_pkg;

	localparam int CHANNELS_DEF     = 15;
	localparam int MAX_RESTARTS_DEF = 50;

	localparam int FAULT_W = 15;
	localparam int INC_W   = 16;
	localparam int LIMIT_W = 31;
	localparam int TIME_W  = 32;
	localparam int COUNT_W = 6;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 31;

	localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_MASK   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TICK_INCREMENT = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_FORGET_TIME    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_COOLDOWN_TIME  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_BLOCK_COUNT    = 3'd4;

	localparam logic [FAULT_W-1:0] MASK_RST     = '0;
	localparam logic [INC_W-1:0]   INC_RST      = 16'd1;
	localparam logic [LIMIT_W-1:0] FORGET_RST   = 31'd1000;
	localparam logic [LIMIT_W-1:0] COOLDOWN_RST = 31'd100;
	localparam logic [COUNT_W-1:0] BLOCK_RST    = 6'd3;

	// per-channel entry held in the state memory
	typedef struct packed {
		logic [TIME_W-1:0]  elapsed;
		logic [COUNT_W-1:0] count;
	} chan_t;

	localparam int CHAN_W = $bits(chan_t);

	// timing thresholds, tick increment and block count seen by the channel update
	typedef struct packed {
		logic [INC_W-1:0]   tick_increment;
		logic [LIMIT_W-1:0] forget_time;
		logic [LIMIT_W-1:0] cooldown_time;
		logic [COUNT_W-1:0] block_count;
	} frl_cfg_t;

	// what the sequencer knows of the channel under evaluation
	typedef struct packed {
		logic enabled;
		logic now;
		logic past;
	} chan_obs_t;

endpackage

/* rtl/frl_ram.sv */
// generic single-write, single-read memory with registered read data
module frl_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

/* rtl/frl_update.sv */
// next-state and grant logic for one channel of one tick
module frl_update import frl_pkg::*; #(
	parameter int MAX_RESTARTS = MAX_RESTARTS_DEF
) (
	input  chan_t     cur,
	input  chan_obs_t obs,
	input  frl_cfg_t  cfg,
	input  logic      grant_in,
	output chan_t     nxt,
	output logic      grant_out
);

	logic [TIME_W-1:0]  e1;
	logic [TIME_W-1:0]  forget_ext;
	logic [TIME_W-1:0]  cool_ext;
	logic [TIME_W:0]    sum;
	logic [TIME_W-1:0]  e_inc;
	logic [COUNT_W-1:0] c1;
	logic               g;

	always_comb begin
		forget_ext = {1'b0, cfg.forget_time};
		cool_ext   = {1'b0, cfg.cooldown_time};
		// a fault edge in either direction restarts the timer
		e1 = (obs.now != obs.past) ? '0 : cur.elapsed;
		sum = {1'b0, e1} + (TIME_W+1)'(cfg.tick_increment);
		e_inc = sum[TIME_W] ? '1 : sum[TIME_W-1:0];
		c1 = cur.count;
		g = grant_in;
		nxt.elapsed = e1;
		nxt.count   = cur.count;
		if (!obs.now) begin
			if (c1 != '0 && e1 <= forget_ext) begin
				nxt.elapsed = e_inc;
			end
			nxt.count = (nxt.elapsed >= forget_ext) ? '0 : c1;
		end else begin
			if (!obs.past && c1 < COUNT_W'(MAX_RESTARTS)) begin
				c1 = c1 + COUNT_W'(1);
			end
			nxt.count = c1;
			if (e1 < cool_ext) begin
				nxt.elapsed = e_inc;
			end else begin
				g = 1'b1;
			end
		end
		if (nxt.count >= cfg.block_count) begin
			g = 1'b0;
		end
		grant_out = obs.enabled ? g : grant_in;
	end

endmodule

/* rtl/fault_restart_limiter_top.sv */
// fault restart limiter: tick sequencer, config registers and state memory
// usage
//   s_axis carries one tick item: tdata[14:0] fault word, tdata[15] clear flag.
//   m_axis returns one item per tick: tdata[0] restart allowed, rest zero.
//   cfg_we/cfg_addr/cfg_wdata write the five registers, only while idle.
// operation
//   per-channel timer and restart count live in a one-port-write, one-port-read
//   memory; each tick walks the channels low to high, reading one entry a cycle
//   and writing the updated entry back the next cycle.
// walk and result
//   the result is registered from the update of the last channel; the length
//   of a tick is set by the single memory read port walking one channel per
//   cycle, and the next tick is accepted only once the walk is done.
// reset
//   all counters read as zero after reset: a valid bit per entry masks stale
//   memory contents, so no clearing pass is needed; a clear tick drops all
//   valid bits at once.
// stalls
//   a finished result waits in the output register; the next tick is accepted
//   meanwhile and only holds at its end if the previous result is still there.
module fault_restart_limiter_top import frl_pkg::*; #(
	parameter int CHANNELS     = CHANNELS_DEF,
	parameter int MAX_RESTARTS = MAX_RESTARTS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	input  logic [15:0]           s_axis_tdata,  // fault_word[14:0], clear_counters[15]
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	output logic [7:0]            m_axis_tdata,  // restart_allowed[0], zero fill
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_addr,
	input  logic [CFG_DATA_W-1:0] cfg_wdata
);

	localparam int AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam logic [AW-1:0] LAST_CH = AW'(CHANNELS - 1);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_HOLD
	} state_t;

	state_t state_q;

	logic [FAULT_W-1:0] mask_q;
	frl_cfg_t           cfg_q;

	logic [FAULT_W-1:0] cur_q;
	logic [FAULT_W-1:0] prev_q;
	logic [CHANNELS-1:0] vld_q;
	logic               grant_q;
	logic               res_q;
	logic               out_q;
	logic               iss_q;
	logic [AW-1:0]      rd_ch_q;
	logic               v_s1;
	logic [AW-1:0]      ch_s1;
	logic               ent_vld_s1;

	logic [CHAN_W-1:0]  rdata;
	chan_t              cur_ent;
	chan_t              nxt_ent;
	chan_obs_t          obs;
	logic               grant_nxt;
	logic               wr_en;
	logic               in_acc;
	logic               out_free;
	logic               out_load;
	logic               last_s1;

	assign s_axis_tready = (state_q == ST_IDLE);
	assign in_acc        = s_axis_tvalid && s_axis_tready;
	assign out_free      = !m_axis_tvalid || m_axis_tready;
	assign m_axis_tdata  = {7'd0, out_q};
	assign last_s1       = v_s1 && (ch_s1 == LAST_CH);
	// a new result enters the output register this cycle
	assign out_load      = out_free && ((state_q == ST_RUN && last_s1) || state_q == ST_HOLD);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q               <= MASK_RST;
			cfg_q.tick_increment <= INC_RST;
			cfg_q.forget_time    <= FORGET_RST;
			cfg_q.cooldown_time  <= COOLDOWN_RST;
			cfg_q.block_count    <= BLOCK_RST;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				REG_CHANNEL_MASK:   mask_q               <= cfg_wdata[FAULT_W-1:0];
				REG_TICK_INCREMENT: cfg_q.tick_increment <= cfg_wdata[INC_W-1:0];
				REG_FORGET_TIME:    cfg_q.forget_time    <= cfg_wdata[LIMIT_W-1:0];
				REG_COOLDOWN_TIME:  cfg_q.cooldown_time  <= cfg_wdata[LIMIT_W-1:0];
				REG_BLOCK_COUNT:    cfg_q.block_count    <= cfg_wdata[COUNT_W-1:0];
				default: ;
			endcase
		end
	end

	// channel walk: read stage then update and write-back stage
	always_comb begin
		cur_ent     = ent_vld_s1 ? chan_t'(rdata) : '0;
		obs.enabled = ((mask_q >> ch_s1) & FAULT_W'(1)) != '0;
		obs.now     = ((cur_q  >> ch_s1) & FAULT_W'(1)) != '0;
		obs.past    = ((prev_q >> ch_s1) & FAULT_W'(1)) != '0;
		wr_en       = v_s1 && obs.enabled;
	end

	frl_update #(
		.MAX_RESTARTS(MAX_RESTARTS)
	) u_update (
		.cur      (cur_ent),
		.obs      (obs),
		.cfg      (cfg_q),
		.grant_in (grant_q),
		.nxt      (nxt_ent),
		.grant_out(grant_nxt)
	);

	frl_ram #(
		.WIDTH(CHAN_W),
		.DEPTH(CHANNELS)
	) u_state_ram (
		.clk  (clk),
		.we   (wr_en),
		.waddr(ch_s1),
		.wdata(nxt_ent),
		.raddr(rd_ch_q),
		.rdata(rdata)
	);

	always_ff @(posedge clk) begin
		ch_s1 <= rd_ch_q;
		if (in_acc) begin
			cur_q <= s_axis_tdata[FAULT_W-1:0];
		end
		if (last_s1) begin
			res_q <= grant_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			prev_q        <= '0;
			vld_q         <= '0;
			grant_q       <= 1'b0;
			iss_q         <= 1'b0;
			rd_ch_q       <= '0;
			v_s1          <= 1'b0;
			ent_vld_s1    <= 1'b0;
			m_axis_tvalid <= 1'b0;
			out_q         <= 1'b0;
		end else begin
			v_s1       <= iss_q;
			ent_vld_s1 <= vld_q[rd_ch_q];
			if (m_axis_tvalid && m_axis_tready && !out_load) begin
				m_axis_tvalid <= 1'b0;
			end
			if (wr_en) begin
				vld_q[ch_s1] <= 1'b1;
			end
			if (v_s1) begin
				grant_q <= grant_nxt;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						if (s_axis_tdata[FAULT_W]) begin
							vld_q <= '0;
						end
						grant_q <= 1'b0;
						rd_ch_q <= '0;
						iss_q   <= 1'b1;
						state_q <= ST_RUN;
					end
				end
				ST_RUN: begin
					if (iss_q) begin
						if (rd_ch_q == LAST_CH) begin
							iss_q <= 1'b0;
						end else begin
							rd_ch_q <= rd_ch_q + AW'(1);
						end
					end
					if (last_s1) begin
						prev_q <= cur_q;
						if (out_free) begin
							m_axis_tvalid <= 1'b1;
							out_q         <= grant_nxt;
							state_q       <= ST_IDLE;
						end else begin
							state_q <= ST_HOLD;
						end
					end
				end
				ST_HOLD: begin
					if (out_free) begin
						m_axis_tvalid <= 1'b1;
						out_q         <= res_q;
						state_q       <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

/* test/testbench.sv */
// stream-level regression of the fault restart limiter against a per-channel predictor
`timescale 1ns / 100ps

module testbench;
	import frl_pkg::*;

	localparam int                   SETTLE_CYCLES = CHANNELS_DEF + 4;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO  = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI  = 3'd7;
	localparam logic [LIMIT_W-1:0]   LIMIT_MAX     = '1;

	// clear flag sits above the fault word, matching the tdata layout
	typedef struct packed {
		logic               clear;
		logic [FAULT_W-1:0] faults;
	} tick_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_axis_tvalid = 1'b0;
	logic                  s_axis_tready;
	logic [15:0]           s_axis_tdata = '0;  // fault_word[14:0], clear_counters[15]
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	logic [7:0]            m_axis_tdata;       // restart_allowed[0], zero fill
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_addr = REG_CHANNEL_MASK;
	logic [CFG_DATA_W-1:0] cfg_wdata = '0;

	fault_restart_limiter_top dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_we        (cfg_we),
		.cfg_addr      (cfg_addr),
		.cfg_wdata     (cfg_wdata)
	);

	// predictor copy of the registers
	logic [FAULT_W-1:0] sup_mask   = MASK_RST;
	logic [INC_W-1:0]   step_inc   = INC_RST;
	logic [LIMIT_W-1:0] forget_lim = FORGET_RST;
	logic [LIMIT_W-1:0] cool_lim   = COOLDOWN_RST;
	logic [COUNT_W-1:0] block_lim  = BLOCK_RST;

	// predictor copy of the channel state
	logic [TIME_W-1:0]  elapsed_q  [CHANNELS_DEF];
	logic [COUNT_W-1:0] restarts_q [CHANNELS_DEF];
	logic [FAULT_W-1:0] last_faults = '0;

	tick_t ticks_to_send [$];
	logic  restart_expect_q [$];
	tick_t held_tick;
	logic  tick_held = 1'b0;
	logic  [7:0] want_byte;

	int unsigned send_idle_pct = 0;
	int unsigned recv_idle_pct = 0;
	int ticks_sent    = 0;
	int results_seen  = 0;
	int grants_seen   = 0;
	int settings_done = 0;
	int mismatches    = 0;

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic logic [TIME_W-1:0] sat_add_time(input logic [TIME_W-1:0] a,
			input logic [INC_W-1:0] b);
		logic [TIME_W:0] s;
		s = {1'b0, a} + {{(TIME_W + 1 - INC_W){1'b0}}, b};
		return s[TIME_W] ? {TIME_W{1'b1}} : s[TIME_W-1:0];
	endfunction

	// one sample tick of the limiter; updates the predictor state
	function automatic logic predict_restart(input tick_t t);
		logic grant;
		logic now_f;
		logic was_f;
		grant = 1'b0;
		for (int ch = 0; ch < CHANNELS_DEF; ch++) begin
			if (t.clear) begin
				elapsed_q[ch]  = '0;
				restarts_q[ch] = '0;
			end
			if (sup_mask[ch]) begin
				now_f = t.faults[ch];
				was_f = last_faults[ch];
				if (!now_f) begin
					if (was_f)
						elapsed_q[ch] = '0;
					// healthy timer only runs while there is a count to forget
					if (restarts_q[ch] != 0 && elapsed_q[ch] <= forget_lim)
						elapsed_q[ch] = sat_add_time(elapsed_q[ch], step_inc);
					if (elapsed_q[ch] >= forget_lim)
						restarts_q[ch] = '0;
				end else begin
					if (!was_f) begin
						elapsed_q[ch] = '0;
						if (restarts_q[ch] < MAX_RESTARTS_DEF)
							restarts_q[ch] = restarts_q[ch] + 1'b1;
					end
					if (elapsed_q[ch] < cool_lim)
						elapsed_q[ch] = sat_add_time(elapsed_q[ch], step_inc);
					else
						grant = 1'b1;
				end
				if (restarts_q[ch] >= block_lim)
					grant = 1'b0;
			end
		end
		last_faults = t.faults;
		return grant;
	endfunction

	// sender: accept at the rising edge, present the next item at the falling edge
	always @(posedge clk) begin
		if (arst_n && s_axis_tvalid && s_axis_tready) begin
			restart_expect_q.push_back(predict_restart(held_tick));
			tick_held = 1'b0;
			ticks_sent++;
		end
	end

	always @(negedge clk) begin
		if (!tick_held) begin
			if (ticks_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				held_tick = ticks_to_send.pop_front();
				tick_held = 1'b1;
				s_axis_tdata <= held_tick;
				s_axis_tvalid <= 1'b1;
			end else begin
				s_axis_tvalid <= 1'b0;
			end
		end
	end

	always @(negedge clk) begin
		m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
	end

	// result checker
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			results_seen++;
			if (restart_expect_q.size() == 0) begin
				mismatches++;
				$display("%0t: result with no tick pending, expected none actual %h",
					$time, m_axis_tdata);
			end else begin
				want_byte = {7'd0, restart_expect_q.pop_front()};
				if (want_byte[0])
					grants_seen++;
				if (m_axis_tdata !== want_byte) begin
					mismatches++;
					if (mismatches <= 40)
						$display("%0t: restart_allowed mismatch, expected %h actual %h",
							$time, want_byte, m_axis_tdata);
				end
			end
		end
	end

	task automatic wait_drained();
		while (ticks_to_send.size() != 0 || tick_held || restart_expect_q.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] val);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_addr  <= idx;
		cfg_wdata <= val;
		case (idx)
			REG_CHANNEL_MASK:   sup_mask   = val[FAULT_W-1:0];
			REG_TICK_INCREMENT: step_inc   = val[INC_W-1:0];
			REG_FORGET_TIME:    forget_lim = val[LIMIT_W-1:0];
			REG_COOLDOWN_TIME:  cool_lim   = val[LIMIT_W-1:0];
			REG_BLOCK_COUNT:    block_lim  = val[COUNT_W-1:0];
			default: ;
		endcase
	endtask

	task automatic program_block(input logic [FAULT_W-1:0] mask, input logic [INC_W-1:0] inc,
			input logic [LIMIT_W-1:0] forget, input logic [LIMIT_W-1:0] cool,
			input logic [COUNT_W-1:0] blk);
		wait_drained();
		write_reg(REG_CHANNEL_MASK, CFG_DATA_W'(mask));
		write_reg(REG_TICK_INCREMENT, CFG_DATA_W'(inc));
		write_reg(REG_FORGET_TIME, forget);
		write_reg(REG_COOLDOWN_TIME, cool);
		write_reg(REG_BLOCK_COUNT, CFG_DATA_W'(blk));
		// an unmapped index last, so a decode that aliases it would show up
		write_reg($urandom_range(1) ? REG_SPARE_HI : REG_SPARE_LO, CFG_DATA_W'($urandom));
		@(negedge clk);
		cfg_we <= 1'b0;
		settings_done++;
	endtask

	task automatic push_tick(input logic [FAULT_W-1:0] faults, input logic clear);
		tick_t t;
		t.faults = faults;
		t.clear  = clear;
		ticks_to_send.push_back(t);
	endtask

	// fault bits follow a sticky random walk so runs last long enough to
	// reach the cooldown and forget times; noise items break the runs
	task automatic fill_random(input int unsigned n, input int unsigned flip16,
			input int unsigned noise16, input int unsigned clear64);
		tick_t t;
		logic [FAULT_W-1:0] walk;
		walk = FAULT_W'($urandom_range(32767));
		for (int i = 0; i < n; i++) begin
			for (int b = 0; b < FAULT_W; b++)
				if ($urandom_range(15) < flip16)
					walk[b] = ~walk[b];
			t.faults = ($urandom_range(15) < noise16) ? FAULT_W'($urandom_range(32767)) : walk;
			t.clear  = ($urandom_range(63) < clear64);
			ticks_to_send.push_back(t);
		end
	endtask

	function automatic logic [FAULT_W-1:0] rand_mask();
		return FAULT_W'($urandom_range(32767));
	endfunction

	initial begin
		for (int ch = 0; ch < CHANNELS_DEF; ch++) begin
			elapsed_q[ch]  = '0;
			restarts_q[ch] = '0;
		end
		send_idle_pct = 21;
		recv_idle_pct = 79;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// reset settings: nothing supervised, so never a grant
		push_tick(15'h7FFF, 1'b0);
		push_tick(15'h0000, 1'b0);
		push_tick(15'h7FFF, 1'b1);

		// cooldown reached, then forget after a healthy stretch, then clears
		program_block(15'h7FFF, 16'd1, 31'd3, 31'd2, 6'd3);
		push_tick(15'h7FFF, 1'b0);
		push_tick(15'h7FFF, 1'b0);
		push_tick(15'h7FFF, 1'b0);
		push_tick(15'h0000, 1'b0);
		push_tick(15'h0000, 1'b0);
		push_tick(15'h0000, 1'b0);
		push_tick(15'h7FFF, 1'b1);
		push_tick(15'h7FFF, 1'b0);

		// unsupervised channels faulting alone, zero cooldown and zero forget
		program_block(15'h5555, 16'd1, 31'd0, 31'd0, 6'd63);
		push_tick(15'h2AAA, 1'b0);
		push_tick(15'h7FFF, 1'b0);
		push_tick(15'h5555, 1'b0);
		push_tick(15'h0000, 1'b0);

		// zero block count blocks everything
		program_block(15'h0001, 16'd1, 31'd1000, 31'd0, 6'd0);
		push_tick(15'h0001, 1'b0);
		push_tick(15'h0000, 1'b0);

		// largest increment and thresholds
		program_block(15'h7FFF, 16'hFFFF, LIMIT_MAX, LIMIT_MAX, 6'd63);
		push_tick(15'h7FFF, 1'b0);
		push_tick(15'h7FFF, 1'b0);
		push_tick(15'h4000, 1'b1);
		push_tick(15'h0000, 1'b0);

		program_block(15'h7FFF, 16'd1, 31'd8, 31'd3, 6'd3);
		fill_random(90, 3, 1, 1);
		program_block(rand_mask(), 16'($urandom_range(1, 4)), 31'($urandom_range(30)),
			31'($urandom_range(12)), 6'($urandom_range(6)));
		fill_random(80, 4, 1, 1);
		// fast toggling with nothing forgotten drives counts to saturation
		program_block(15'h7FFF, 16'd1, LIMIT_MAX, 31'd1, 6'd50);
		fill_random(140, 14, 0, 0);

		wait_drained();
		send_idle_pct = 79;
		recv_idle_pct = 21;
		program_block(rand_mask(), 16'hFFFF, 31'd200000, 31'd131070, 6'd2);
		fill_random(70, 3, 1, 1);
		// zero increment: timers never move
		program_block(rand_mask(), 16'd0, 31'd5, 31'd0, 6'd4);
		fill_random(60, 4, 1, 1);
		program_block(rand_mask(), 16'd2, 31'd0, 31'd4, 6'd2);
		fill_random(70, 3, 2, 1);

		wait_drained();
		send_idle_pct = 0;
		recv_idle_pct = 0;
		program_block(rand_mask(), 16'($urandom_range(1, 8)), 31'($urandom_range(60)),
			31'($urandom_range(20)), 6'($urandom_range(8)));
		fill_random(60, 2, 1, 1);
		program_block(15'h7FFF, 16'd3, 31'd12, 31'd5, 6'd63);
		fill_random(60, 3, 2, 2);

		wait_drained();
		$display("%0d ticks sent over %0d register settings, %0d results checked",
			ticks_sent, settings_done, results_seen);
		$display("%0d results granted a restart, %0d mismatches", grants_seen, mismatches);
		if (mismatches == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

	initial begin
		#5_000_000;
		$display("timeout with %0d ticks queued and %0d results outstanding",
			ticks_to_send.size(), restart_expect_q.size());
		$display("[FAIL] regression broken");
		$finish;
	end

endmodule
